FILE: sv/asc_pkg.sv
// Shared types and constants for the AABB segment clipper.
package asc_pkg;

  localparam int VW = 32;            // value width
  localparam int FB = 16;            // fraction bits
  localparam int NLANE = 6;          // slab tests per item
  localparam int RW = VW + FB;       // dividend width
  localparam int DW = 2 * VW - 1;    // shifted divisor width
  localparam int CW = (RW > DW) ? RW : DW;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [VW-1:0] origin_x;
    logic signed [VW-1:0] origin_y;
    logic signed [VW-1:0] origin_z;
    logic signed [VW-1:0] dir_x;
    logic signed [VW-1:0] dir_y;
    logic signed [VW-1:0] dir_z;
    logic signed [VW-1:0] t_enter_in;
    logic signed [VW-1:0] t_exit_in;
  } in_t;

  typedef struct packed {
    logic                 inside_res;
    logic signed [VW-1:0] t_enter;
    logic signed [VW-1:0] t_exit;
  } out_t;

  // one slab test in flight
  typedef struct packed {
    logic [RW-1:0] rem;    // partial remainder
    logic [DW-1:0] dsh;    // divisor aligned to current quotient bit
    logic [VW-1:0] quo;
    logic          sat;
    logic          rneg;
    logic          pneg;
    logic          pzero;
    logic          qpos;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0]    lane;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 ok;
  } work_t;

endpackage

FILE: sv/asc_prep.sv
// Entry stage: slab distances, slopes and saturation check.
module asc_prep import asc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  in_t                  data_i,
  input  logic [VW-1:0]        box_i [NLANE],
  output logic                 vld_o,
  output work_t                work_o
);

  function automatic lane_t mk_lane(logic signed [VW-1:0] a, logic signed [VW-1:0] b,
                                    logic pneg, logic [VW-1:0] mp);
    lane_t             l;
    logic signed [VW:0] diff;
    logic [VW-1:0]     mq;
    logic [2*VW-1:0]   lim;
    logic [2*VW-1:0]   num;
    diff = {a[VW-1], a} - {b[VW-1], b};
    mq   = diff[VW] ? VW'(-diff) : diff[VW-1:0];
    l.rneg  = (diff[VW] == pneg);
    l.pneg  = pneg;
    l.pzero = (mp == '0);
    l.qpos  = !diff[VW] && (mq != '0);
    l.rem   = {mq, {FB{1'b0}}};
    l.dsh   = {mp, {(VW-1){1'b0}}};
    l.quo   = '0;
    // quotient above cap iff num >= (cap+1)*mp
    num   = (2*VW)'(l.rem);
    lim   = (2*VW)'({mp, {(VW-1){1'b0}}}) + (l.rneg ? (2*VW)'(mp) : '0);
    l.sat = (num >= lim);
    return l;
  endfunction

  logic [VW-1:0] mp [3];
  logic          dn [3];
  logic signed [VW-1:0] org [3];
  work_t work_d, work_q;
  logic  vld_q;

  assign org[0] = data_i.origin_x;
  assign org[1] = data_i.origin_y;
  assign org[2] = data_i.origin_z;
  assign dn[0]  = data_i.dir_x[VW-1];
  assign dn[1]  = data_i.dir_y[VW-1];
  assign dn[2]  = data_i.dir_z[VW-1];
  assign mp[0]  = dn[0] ? -data_i.dir_x : data_i.dir_x;
  assign mp[1]  = dn[1] ? -data_i.dir_y : data_i.dir_y;
  assign mp[2]  = dn[2] ? -data_i.dir_z : data_i.dir_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      work_d.lane[2*a]   = mk_lane(box_i[a], org[a], !dn[a], mp[a]);
      work_d.lane[2*a+1] = mk_lane(org[a], box_i[a+3], dn[a], mp[a]);
    end
    work_d.lo = data_i.t_enter_in;
    work_d.hi = data_i.t_exit_in;
    work_d.ok = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule

FILE: sv/asc_div_cell.sv
// Divider cell: one quotient bit for every lane.
module asc_div_cell import asc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  work_t work_i,
  output logic  vld_o,
  output work_t work_o
);

  work_t work_d, work_q;
  logic  vld_q;

  always_comb begin
    work_d = work_i;
    for (int i = 0; i < NLANE; i++) begin
      if (CW'(work_i.lane[i].rem) >= CW'(work_i.lane[i].dsh)) begin
        work_d.lane[i].rem = RW'(CW'(work_i.lane[i].rem) - CW'(work_i.lane[i].dsh));
        work_d.lane[i].quo = {work_i.lane[i].quo[VW-2:0], 1'b1};
      end else begin
        work_d.lane[i].quo = {work_i.lane[i].quo[VW-2:0], 1'b0};
      end
      work_d.lane[i].dsh = work_i.lane[i].dsh >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule

FILE: sv/asc_slab_cell.sv
// Slab cell: applies the head lane to the interval, shifts lanes down.
module asc_slab_cell import asc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  work_t work_i,
  output logic  vld_o,
  output work_t work_o
);

  lane_t l;
  logic [VW-1:0] cap;
  logic [VW-1:0] mag;
  logic signed [VW:0] rw;
  logic signed [VW-1:0] r;
  work_t work_d, work_q;
  logic  vld_q;

  assign l   = work_i.lane[0];
  assign cap = l.rneg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  assign mag = l.sat ? cap : l.quo;
  assign rw  = l.rneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign r   = rw[VW-1:0];

  always_comb begin
    work_d = work_i;
    for (int i = 0; i < NLANE - 1; i++) begin
      work_d.lane[i] = work_i.lane[i+1];
    end
    if (work_i.ok) begin
      if (l.pzero) begin
        work_d.ok = !l.qpos;
      end else if (l.pneg) begin
        if (r > work_i.hi) work_d.ok = 1'b0;
        else if (r > work_i.lo) work_d.lo = r;
      end else begin
        if (r < work_i.lo) work_d.ok = 1'b0;
        else if (r < work_i.hi) work_d.hi = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule

FILE: sv/aabb_segment_clip.sv
// Pipeline: entry stage, 32 divider cells and 6 slab cells from input transaction
//   to result; the last slab cell is the output register.
// Throughput: one transaction per cycle; the whole row advances together and
//   halts only while a finished result sits unclaimed under out_stall_i.
// Reset: box registers return to min 0.0 / max 1.0, all stage valids clear.
// Config writes are always ready and take effect for the next input transaction.
module aabb_segment_clip import asc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_t           in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_t          out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [VW-1:0] cfg_data_i
);

  localparam int NDIV = VW;
  localparam int NST  = 1 + NDIV + NLANE;

  // box bounds: min x,y,z then max x,y,z
  logic [VW-1:0] box_q [NLANE];

  // stage chain
  logic  vld [NST+1];
  work_t work [1:NST];
  logic  en;

  // Row moves as a unit unless the output holds a result that is stalled.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[REG_MIN_X] <= '0;
      box_q[REG_MIN_Y] <= '0;
      box_q[REG_MIN_Z] <= '0;
      box_q[REG_MAX_X] <= VW'(1) << FB;
      box_q[REG_MAX_Y] <= VW'(1) << FB;
      box_q[REG_MAX_Z] <= VW'(1) << FB;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_X: box_q[REG_MIN_X] <= cfg_data_i;
        REG_MIN_Y: box_q[REG_MIN_Y] <= cfg_data_i;
        REG_MIN_Z: box_q[REG_MIN_Z] <= cfg_data_i;
        REG_MAX_X: box_q[REG_MAX_X] <= cfg_data_i;
        REG_MAX_Y: box_q[REG_MAX_Y] <= cfg_data_i;
        REG_MAX_Z: box_q[REG_MAX_Z] <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign vld[0]  = in_valid_i;

  // Entry stage: signed distances to each slab plane, direction magnitudes,
  // and an early saturation decision so the dividers need only VW bits.
  asc_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld[0]),
    .data_i (in_data_i),
    .box_i  (box_q),
    .vld_o  (vld[1]),
    .work_o (work[1])
  );

  // Restoring division, one quotient bit per cell for all six slabs at once.
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    asc_div_cell u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[1+g]),
      .work_i (work[1+g]),
      .vld_o  (vld[2+g]),
      .work_o (work[2+g])
    );
  end

  // Slab tests in order x-min .. z-max; a rejection freezes the interval.
  for (genvar g = 0; g < NLANE; g++) begin : g_slab
    asc_slab_cell u_slab (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[1+NDIV+g]),
      .work_i (work[1+NDIV+g]),
      .vld_o  (vld[2+NDIV+g]),
      .work_o (work[2+NDIV+g])
    );
  end

  assign out_valid_o          = vld[NST];
  assign out_data_o.inside_res = work[NST].ok;
  assign out_data_o.t_enter    = work[NST].lo;
  assign out_data_o.t_exit     = work[NST].hi;

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result is blocked");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld[1])
    else $error("accepted transaction not in entry stage");
`endif

endmodule
